@@ rtl/core/rgcd_pkg.sv @@
// Package for the RSSI gate crossing detector: widths, command and register codes.
package rgcd_pkg;

  localparam int RssiBitsDefault = 8;
  localparam int TimeBitsDefault = 32;

  localparam int CfgDataW = 8;
  localparam int CfgIdxW  = 2;
  localparam int LapW     = 8;
  localparam int CmdW     = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_CALIBRATE = 2'd1,
    CMD_END       = 2'd2,
    CMD_RESET     = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLED   = 2'd0,
    CFG_CAL_THR   = 2'd1,
    CFG_CAL_OFS   = 2'd2,
    CFG_EXIT_THR  = 2'd3
  } cfg_idx_e;

endpackage

@@ rtl/core/rssi_gate_crossing_detector.sv @@
// RSSI gate crossing detector: input stage, per-item state update and result register.
//
// Usage: each request on the input channel (in_valid_i / in_stall_o) is either a
// filtered RSSI sample with its timestamp or a command (calibrate, end crossing,
// reset state). Every request yields exactly one result on the output channel
// (out_valid_o / out_stall_i) carrying the crossing flags, trigger level and the
// record of the last completed pass.
// Pipeline: a request passes the input register, then the state update and result
// register; out_stall_i can hold it in the input register between the two.
// Throughput: one request per cycle unless out_stall_i holds the result; the state
// update is combinational (compare, add, two chained halving adds on the timestamp).
// Stall: while out_stall_i holds the result, one more request is taken into the
// input register; in_stall_o rises only when both registers are full.
// Configuration: cfg_valid_i / cfg_ready_o, always ready; write only while idle.
// Reset: asynchronous, clears the detector state, configuration and both valid flags.
module rssi_gate_crossing_detector
  import rgcd_pkg::*;
#(
  parameter int RSSI_BITS = RssiBitsDefault,
  parameter int TIME_BITS = TimeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CmdW-1:0]      command_i,
  input  logic [RSSI_BITS-1:0] rssi_value_i,
  input  logic [TIME_BITS-1:0] sample_time_i,
  input  logic                 sample_ready_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 in_crossing_o,
  output logic                 calibrating_o,
  output logic [RSSI_BITS-1:0] trigger_level_o,
  output logic                 pass_done_o,
  output logic [RSSI_BITS-1:0] pass_peak_o,
  output logic [TIME_BITS-1:0] pass_time_o,
  output logic [TIME_BITS-1:0] lap_time_o,
  output logic [LapW-1:0]      lap_count_o,
  output logic                 state_valid_o
);

  // configuration
  logic                en_q;
  logic [CfgDataW-1:0] cal_thr_q, cal_ofs_q, exit_thr_q;

  // input stage
  logic                 s1_valid_q, s1_valid_d;
  cmd_e                 cmd_q;
  logic [RSSI_BITS-1:0] rssi_q;
  logic [TIME_BITS-1:0] time_q;
  logic                 rdy_q;

  // detector state
  logic                 cross_q, cross_d;
  logic                 cal_q, cal_d;
  logic [RSSI_BITS-1:0] cur_q, cur_d;
  logic [RSSI_BITS-1:0] trig_q, trig_d;
  logic [RSSI_BITS-1:0] peak_q, peak_d;
  logic [TIME_BITS-1:0] pt_q, pt_d;
  logic [RSSI_BITS-1:0] lpeak_q, lpeak_d;
  logic [TIME_BITS-1:0] lpt_q, lpt_d;
  logic [TIME_BITS-1:0] lap_q, lap_d;
  logic [LapW-1:0]      laps_q, laps_d;
  logic                 done_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic                 res_done_q;

  logic                 in_fire, proc_go;
  logic [RSSI_BITS-1:0] cal_thr_x, cal_ofs_x, exit_thr_x;
  logic                 start_hit, cross_now, cal_raise, exit_hit, peak_gt, peak_eq;
  logic [RSSI_BITS-1:0] trig_smp, peak_smp;
  logic [TIME_BITS-1:0] half1, half2, pt_smp;

  function automatic logic [TIME_BITS-1:0] half_sum(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
    return (a >> 1) + (b >> 1) + TIME_BITS'(a[0] & b[0]);
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      cal_thr_q  <= '0;
      cal_ofs_q  <= '0;
      exit_thr_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLED:  en_q       <= cfg_data_i[0];
        CFG_CAL_THR:  cal_thr_q  <= cfg_data_i;
        CFG_CAL_OFS:  cal_ofs_q  <= cfg_data_i;
        CFG_EXIT_THR: exit_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign proc_go    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !proc_go;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (proc_go) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (proc_go) begin
      out_valid_d = 1'b1;
    end
  end

  // sample datapath
  assign cal_thr_x  = RSSI_BITS'(cal_thr_q);
  assign cal_ofs_x  = RSSI_BITS'(cal_ofs_q);
  assign exit_thr_x = RSSI_BITS'(exit_thr_q);

  assign start_hit = (rssi_q > trig_q) && (rssi_q >= cal_thr_x);
  assign cross_now = cross_q || start_hit;
  assign peak_gt   = rssi_q > peak_q;
  assign peak_eq   = rssi_q == peak_q;
  assign half1     = half_sum(time_q, pt_q);
  assign half2     = half_sum(time_q, half1);
  assign peak_smp  = peak_gt ? rssi_q : peak_q;
  assign pt_smp    = peak_gt ? time_q : (peak_eq ? half2 : pt_q);

  // trigger + offset < rssi covers both the no-underflow and the raise test
  assign cal_raise = ({1'b0, trig_q} + {1'b0, cal_ofs_x}) < {1'b0, rssi_q};
  assign trig_smp  = (cal_q && cal_raise) ? (rssi_q - cal_ofs_x) : trig_q;
  // rssi + exit < trigger covers both the trigger above exit test and the drop
  assign exit_hit  = ({1'b0, rssi_q} + {1'b0, exit_thr_x}) < {1'b0, trig_smp};

  always_comb begin
    cross_d = cross_q;
    cal_d   = cal_q;
    cur_d   = cur_q;
    trig_d  = trig_q;
    peak_d  = peak_q;
    pt_d    = pt_q;
    lpeak_d = lpeak_q;
    lpt_d   = lpt_q;
    lap_d   = lap_q;
    laps_d  = laps_q;
    done_d  = 1'b0;
    if (proc_go) begin
      unique case (cmd_q)
        CMD_SAMPLE: begin
          if (rdy_q && en_q) begin
            cur_d = rssi_q;
            if (cross_now) begin
              cross_d = 1'b1;
              peak_d  = peak_smp;
              pt_d    = pt_smp;
              trig_d  = trig_smp;
              if (exit_hit) begin
                lpeak_d = peak_smp;
                lap_d   = pt_smp - lpt_q;
                lpt_d   = pt_smp;
                laps_d  = laps_q + LapW'(1);
                cross_d = 1'b0;
                cal_d   = 1'b0;
                peak_d  = '0;
                done_d  = 1'b1;
              end
            end
          end
        end
        CMD_CALIBRATE: begin
          cross_d = 1'b0;
          cal_d   = 1'b1;
          peak_d  = '0;
          trig_d  = cur_q;
        end
        CMD_END: begin
          lpeak_d = peak_q;
          lap_d   = pt_q - lpt_q;
          lpt_d   = pt_q;
          laps_d  = laps_q + LapW'(1);
          cross_d = 1'b0;
          cal_d   = 1'b0;
          peak_d  = '0;
          done_d  = 1'b1;
        end
        CMD_RESET: begin
          cross_d = 1'b0;
          peak_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cross_q     <= 1'b0;
      cal_q       <= 1'b0;
      cur_q       <= '0;
      trig_q      <= '0;
      peak_q      <= '0;
      pt_q        <= '0;
      lpeak_q     <= '0;
      lpt_q       <= '0;
      lap_q       <= '0;
      laps_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      cross_q     <= cross_d;
      cal_q       <= cal_d;
      cur_q       <= cur_d;
      trig_q      <= trig_d;
      peak_q      <= peak_d;
      pt_q        <= pt_d;
      lpeak_q     <= lpeak_d;
      lpt_q       <= lpt_d;
      lap_q       <= lap_d;
      laps_q      <= laps_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_e'(command_i);
      rssi_q <= rssi_value_i;
      time_q <= sample_time_i;
      rdy_q  <= sample_ready_i;
    end
    if (proc_go) begin
      res_done_q <= done_d;
    end
  end

  // state registers hold the result until the next request is processed
  assign out_valid_o     = out_valid_q;
  assign in_crossing_o   = cross_q;
  assign calibrating_o   = cal_q;
  assign trigger_level_o = trig_q;
  assign pass_done_o     = res_done_q;
  assign pass_peak_o     = lpeak_q;
  assign pass_time_o     = lpt_q;
  assign lap_time_o      = lap_q;
  assign lap_count_o     = laps_q;
  assign state_valid_o   = cur_q <= peak_q;

`ifndef NO_ASSERTIONS
  a_peak_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cross_q |-> peak_q == '0)
    else $error("peak level held outside a crossing");

  a_pass_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pass_done_o |-> !in_crossing_o && !calibrating_o)
    else $error("pass result with crossing or calibration still set");

  a_lap_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_go && done_d |=> laps_q == $past(laps_q) + LapW'(1))
    else $error("lap count did not advance on a pass");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with free room");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc_go |=> $stable(laps_q) && $stable(trig_q) && $stable(cross_q))
    else $error("state changed without a processed request");
`endif

endmodule

@@ tb/rssi_gate_crossing_detector_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the RSSI gate crossing detector.
module rssi_gate_crossing_detector_tb;
  import rgcd_pkg::*;

  localparam int RW         = RssiBitsDefault;
  localparam int TW         = TimeBitsDefault;
  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 64;
  localparam int LapTarget  = 300;

  typedef struct {
    cmd_e          cmd;
    logic [RW-1:0] rssi;
    logic [TW-1:0] stamp;
    logic          ready;
  } gate_request_t;

  typedef struct {
    logic            in_crossing;
    logic            calibrating;
    logic [RW-1:0]   trigger_level;
    logic            pass_done;
    logic [RW-1:0]   pass_peak;
    logic [TW-1:0]   pass_time;
    logic [TW-1:0]   lap_time;
    logic [LapW-1:0] lap_count;
    logic            state_valid;
  } pass_report_t;

  class gate_pass_tracker;
    bit              enabled;
    logic [RW-1:0]   cal_thr = '0;
    logic [RW-1:0]   cal_ofs = '0;
    logic [RW-1:0]   exit_thr = '0;
    bit              crossing;
    bit              calib;
    logic [RW-1:0]   cur_rssi = '0;
    logic [RW-1:0]   trig = '0;
    logic [RW-1:0]   peak = '0;
    logic [RW-1:0]   last_peak = '0;
    logic [TW-1:0]   peak_t = '0;
    logic [TW-1:0]   last_t = '0;
    logic [TW-1:0]   lap_t = '0;
    logic [LapW-1:0] laps = '0;
    pass_report_t    pending_reports[$];
    int              errors;
    int              checked;
    int              samples;
    int              commands;
    int              passes;

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_ENABLED:  enabled  = val[0];
        CFG_CAL_THR:  cal_thr  = val;
        CFG_CAL_OFS:  cal_ofs  = val;
        CFG_EXIT_THR: exit_thr = val;
      endcase
    endfunction

    // floor of the mean, from a sum one bit wider than the operands
    function logic [TW-1:0] mid_time(logic [TW-1:0] a, logic [TW-1:0] b);
      logic [TW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TW:1];
    endfunction

    function void close_pass();
      last_peak = peak;
      lap_t     = peak_t - last_t;
      last_t    = peak_t;
      laps      = laps + LapW'(1);
      crossing  = 1'b0;
      calib     = 1'b0;
      peak      = '0;
      passes++;
    endfunction

    function void record_request(gate_request_t r);
      pass_report_t want;
      bit           done;
      done = 1'b0;
      case (r.cmd)
        CMD_SAMPLE: begin
          samples++;
          if (r.ready && enabled) begin
            cur_rssi = r.rssi;
            if (!crossing && r.rssi > trig && r.rssi >= cal_thr) crossing = 1'b1;
            if (crossing) begin
              if (r.rssi > peak) begin
                peak   = r.rssi;
                peak_t = r.stamp;
              end else if (r.rssi == peak) begin
                peak_t = mid_time(r.stamp, peak_t);
              end
              if (calib && r.rssi >= cal_ofs && trig < r.rssi - cal_ofs)
                trig = r.rssi - cal_ofs;
              if (r.rssi == peak) peak_t = mid_time(r.stamp, peak_t);
              if (trig > exit_thr && r.rssi < trig - exit_thr) begin
                close_pass();
                done = 1'b1;
              end
            end
          end
        end
        CMD_CALIBRATE: begin
          crossing = 1'b0;
          calib    = 1'b1;
          peak     = '0;
          trig     = cur_rssi;
        end
        CMD_END: begin
          close_pass();
          done = 1'b1;
        end
        CMD_RESET: begin
          crossing = 1'b0;
          peak     = '0;
        end
      endcase
      if (r.cmd != CMD_SAMPLE) commands++;
      want.in_crossing   = crossing;
      want.calibrating   = calib;
      want.trigger_level = trig;
      want.pass_done     = done;
      want.pass_peak     = last_peak;
      want.pass_time     = last_t;
      want.lap_time      = lap_t;
      want.lap_count     = laps;
      want.state_valid   = (cur_rssi <= peak);
      pending_reports.push_back(want);
    endfunction

    function void compare_field(string name, logic [TW-1:0] want, logic [TW-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(pass_report_t got);
      pass_report_t want;
      if (pending_reports.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      compare_field("in_crossing", TW'(want.in_crossing), TW'(got.in_crossing));
      compare_field("calibrating", TW'(want.calibrating), TW'(got.calibrating));
      compare_field("trigger_level", TW'(want.trigger_level), TW'(got.trigger_level));
      compare_field("pass_done", TW'(want.pass_done), TW'(got.pass_done));
      compare_field("pass_peak", TW'(want.pass_peak), TW'(got.pass_peak));
      compare_field("pass_time", want.pass_time, got.pass_time);
      compare_field("lap_time", want.lap_time, got.lap_time);
      compare_field("lap_count", TW'(want.lap_count), TW'(got.lap_count));
      compare_field("state_valid", TW'(want.state_valid), TW'(got.state_valid));
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [CmdW-1:0]     command_i      = '0;
  logic [RW-1:0]       rssi_value_i   = '0;
  logic [TW-1:0]       sample_time_i  = '0;
  logic                sample_ready_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                in_crossing_o;
  logic                calibrating_o;
  logic [RW-1:0]       trigger_level_o;
  logic                pass_done_o;
  logic [RW-1:0]       pass_peak_o;
  logic [TW-1:0]       pass_time_o;
  logic [TW-1:0]       lap_time_o;
  logic [LapW-1:0]     lap_count_o;
  logic                state_valid_o;

  gate_pass_tracker tracker = new;

  bit            hold_req;
  bit            sender_calm;
  bit            sink_calm;
  logic [TW-1:0] stamp = '0;
  int            useful_reqs;
  int            cfg_writes;
  int            cycles;

  rssi_gate_crossing_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .rssi_value_i   (rssi_value_i),
    .sample_time_i  (sample_time_i),
    .sample_ready_i (sample_ready_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .in_crossing_o  (in_crossing_o),
    .calibrating_o  (calibrating_o),
    .trigger_level_o(trigger_level_o),
    .pass_done_o    (pass_done_o),
    .pass_peak_o    (pass_peak_o),
    .pass_time_o    (pass_time_o),
    .lap_time_o     (lap_time_o),
    .lap_count_o    (lap_count_o),
    .state_valid_o  (state_valid_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        tracker.check_report('{in_crossing: in_crossing_o, calibrating: calibrating_o,
                               trigger_level: trigger_level_o, pass_done: pass_done_o,
                               pass_peak: pass_peak_o, pass_time: pass_time_o,
                               lap_time: lap_time_o, lap_count: lap_count_o,
                               state_valid: state_valid_o});
      if (in_valid_i && !in_stall_o)
        tracker.record_request('{cmd: cmd_e'(command_i), rssi: rssi_value_i,
                                 stamp: sample_time_i, ready: sample_ready_i});
    end
  end

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 80) return $urandom_range(3, 1);
    if (roll < 96) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [RW-1:0] pick_level();
    case ($urandom_range(3, 0))
      0: return '0;
      1: return '1;
      default: return RW'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [TW-1:0] next_stamp();
    if ($urandom_range(39, 0) == 0) stamp = TW'($urandom());
    else stamp = stamp + TW'($urandom_range(40, 1));
    return stamp;
  endfunction

  // result side: random stalls, calm stretches, and one long hold-off on request
  initial begin : result_sink
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (sink_calm || $urandom_range(2, 0) != 0) begin
        out_stall_i <= 1'b0;
        repeat (sink_calm ? 1 : gap_len()) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (gap_len()) @(posedge clk_i);
      end
    end
  end

  task automatic push_request(cmd_e cmd, logic [RW-1:0] rssi, logic [TW-1:0] stamp_v,
                              logic rdy);
    command_i      <= cmd;
    rssi_value_i   <= rssi;
    sample_time_i  <= stamp_v;
    sample_ready_i <= rdy;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd != CMD_SAMPLE || (rdy && tracker.enabled)) useful_reqs++;
    if (!sender_calm && $urandom_range(1, 0) == 1) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  task automatic send_sample(logic [RW-1:0] rssi);
    push_request(CMD_SAMPLE, rssi, next_stamp(), 1'b1);
  endtask

  task automatic send_noise();
    int unsigned roll;
    cmd_e        cmd;
    roll = $urandom_range(99, 0);
    cmd  = roll < 60 ? CMD_SAMPLE : roll < 72 ? CMD_CALIBRATE : roll < 86 ? CMD_END : CMD_RESET;
    push_request(cmd, RW'($urandom()), TW'($urandom()), 1'($urandom_range(1, 0)));
  endtask

  // rise above the trigger, hold a plateau of equal peaks, then fall away
  task automatic run_crossing();
    int unsigned floor_lvl, top, lo, n_up, k;
    if (tracker.trig > 8'd200 || $urandom_range(3, 0) == 0) begin
      send_sample(RW'($urandom_range(20, 0)));
      push_request(CMD_CALIBRATE, RW'($urandom()), TW'($urandom()),
                   1'($urandom_range(1, 0)));
    end
    floor_lvl = 32'(tracker.trig) + 1;
    if (32'(tracker.cal_thr) > floor_lvl) floor_lvl = 32'(tracker.cal_thr);
    if (floor_lvl > 255) floor_lvl = 255;
    top  = $urandom_range(255, floor_lvl);
    lo   = floor_lvl / 2;
    n_up = $urandom_range(4, 1);
    for (k = 1; k <= n_up; k++) send_sample(RW'(lo + (top - lo) * k / n_up));
    repeat ($urandom_range(3, 0)) send_sample(RW'(top));
    repeat ($urandom_range(3, 1)) send_sample(RW'($urandom_range(top, 0)));
  endtask

  task automatic run_mix(int n);
    int target;
    target = useful_reqs + n;
    while (useful_reqs < target) begin
      if ($urandom_range(3, 0) == 0) send_noise();
      else run_crossing();
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_reg(idx, val);
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic configure(logic en, logic [RW-1:0] thr, logic [RW-1:0] ofs,
                           logic [RW-1:0] ext);
    drain();
    write_reg(CFG_ENABLED, CfgDataW'(en));
    write_reg(CFG_CAL_THR, thr);
    write_reg(CFG_CAL_OFS, ofs);
    write_reg(CFG_EXIT_THR, ext);
  endtask

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // block still disabled
    push_request(CMD_SAMPLE, 8'd200, 32'd5, 1'b1);
    push_request(CMD_CALIBRATE, 8'd0, 32'd0, 1'b0);
    push_request(CMD_END, 8'd0, 32'd0, 1'b0);
    configure(1'b1, 8'd50, 8'd20, 8'd30);
    push_request(CMD_SAMPLE, 8'd255, 32'hFFFF_FFFF, 1'b0);
    push_request(CMD_CALIBRATE, 8'hAA, 32'h5555_5555, 1'b1);
    push_request(CMD_SAMPLE, 8'd40, 32'd100, 1'b1);
    push_request(CMD_SAMPLE, 8'd100, 32'd1000, 1'b1);
    push_request(CMD_SAMPLE, 8'd100, 32'd1011, 1'b1);
    push_request(CMD_SAMPLE, 8'd255, 32'hFFFF_FFFF, 1'b1);
    push_request(CMD_SAMPLE, 8'd255, 32'hFFFF_FFFE, 1'b1);
    push_request(CMD_SAMPLE, 8'd150, 32'hFFFF_FFF0, 1'b1);
    // offset above rssi, trigger below exit threshold, wrapping lap time
    configure(1'b1, 8'd0, 8'd255, 8'd255);
    push_request(CMD_CALIBRATE, 8'd0, 32'd0, 1'b1);
    push_request(CMD_SAMPLE, 8'd200, 32'd20, 1'b1);
    push_request(CMD_SAMPLE, 8'd0, 32'd30, 1'b1);
    push_request(CMD_END, 8'd255, 32'hFFFF_FFFF, 1'b0);
    push_request(CMD_SAMPLE, 8'd255, 32'd40, 1'b1);
    push_request(CMD_RESET, 8'd255, 32'hFFFF_FFFF, 1'b1);
    push_request(CMD_END, 8'd0, 32'd0, 1'b1);
    configure(1'b1, 8'd255, 8'd0, 8'd0);
    push_request(CMD_SAMPLE, 8'd255, 32'd50, 1'b1);
    push_request(CMD_SAMPLE, 8'd254, 32'd60, 1'b1);
    push_request(CMD_SAMPLE, 8'd0, 32'd70, 1'b0);

    // back to back on both sides
    sender_calm = 1'b1;
    sink_calm   = 1'b1;
    configure(1'b1, pick_level(), pick_level(), pick_level());
    run_mix(70);
    sink_calm = 1'b0;

    // long hold-off on the result side with requests still offered
    configure(1'b1, 8'd0, pick_level(), pick_level());
    hold_req = 1'b1;
    while (hold_req) @(posedge clk_i);
    run_mix(15);
    sender_calm = 1'b0;
    run_mix(55);

    // disabled: samples ignored, commands still act
    configure(1'b0, pick_level(), pick_level(), pick_level());
    repeat (15) send_noise();

    configure(1'b1, 8'd255, 8'd255, 8'd255);
    run_mix(40);
    configure(1'b1, pick_level(), pick_level(), pick_level());
    run_mix(40);
    configure(1'b1, 8'd0, 8'd0, 8'd0);
    run_mix(30);
    drain();
    run_mix(30);

    // enough passes to wrap the lap counter
    configure(1'b1, pick_level(), pick_level(), RW'($urandom_range(40, 0)));
    while (tracker.passes < LapTarget) begin
      if ($urandom_range(9, 0) != 0)
        push_request(CMD_END, RW'($urandom()), TW'($urandom()), 1'($urandom_range(1, 0)));
      else
        run_crossing();
    end

    drain();
    $display("checked %0d results from %0d samples and %0d commands, %0d passes closed",
             tracker.checked, tracker.samples, tracker.commands, tracker.passes);
    $display("%0d register writes over zero, full-scale and random thresholds, %0d cycles",
             cfg_writes, cycles);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
